// ===== rtl/tccw_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the text console cell writer.
// Used by the top level, the screen store and the port checker.
package tccw_pkg;

    localparam int COLUMNS    = 80;
    localparam int ROWS       = 25;
    localparam int CELLS      = ROWS * COLUMNS;
    localparam int ROW_W      = $clog2(ROWS + 1);
    localparam int COL_W      = $clog2(COLUMNS + 1);
    localparam int ADDR_W     = $clog2(CELLS + 1);
    localparam int CELL_W     = 16;
    localparam int COLOR_W    = 4;

    localparam logic [7:0]         NEWLINE_CODE = 8'h0A;
    localparam logic [7:0]         SPACE_CODE   = 8'h20;
    localparam logic [COLOR_W-1:0] FG_RESET     = 4'd7;
    localparam logic [COLOR_W-1:0] BG_RESET     = 4'd0;

    typedef enum logic [1:0] {
        CMD_PUT   = 2'd0,
        CMD_SET   = 2'd1,
        CMD_CLEAR = 2'd2,
        CMD_READ  = 2'd3
    } t_cmd;

    typedef enum logic [0:0] {
        CFG_FG = 1'b0,
        CFG_BG = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        t_cmd              command;
        logic [7:0]        char_code;
        logic signed [7:0] row;
        logic signed [7:0] col;
    } t_in_item;

    typedef struct packed {
        logic [4:0]  cursor_row;
        logic [6:0]  cursor_col;
        logic [10:0] cursor_position;
        logic [15:0] read_cell;
        logic        scrolled;
    } t_out_item;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SCROLL,
        ST_WAIT,
        ST_RDATA,
        ST_DONE
    } t_state;

    typedef enum logic [2:0] {
        SOP_NOP,
        SOP_WRITE,
        SOP_READ,
        SOP_CLEAR,
        SOP_SCROLL
    } t_scr_op;

    typedef enum logic [1:0] {
        SCR_IDLE,
        SCR_CLEAR,
        SCR_SHIFT
    } t_scr_state;

    // request from the controller to the screen store
    typedef struct packed {
        t_scr_op             op;
        logic [ADDR_W-1:0]   addr;
        logic [CELL_W-1:0]   data;
    } t_scr_req;

    typedef struct packed {
        logic                busy;
        logic [CELL_W-1:0]   rdata;
    } t_scr_sts;

endpackage

// ===== rtl/text_console_cell_writer_top.sv =====
`timescale 1ns / 1ps
// Put and set cursor are executed in ST_EXEC; read cell then takes its registered read in ST_RDATA;
// clear and a put that scrolls wait in ST_WAIT while the store sweeps all cells, one store cycle per cell.
// Throughput: one request in flight; the next is taken the cycle after the result loads.
// Reset (synchronous, active low): cursor home, fg 7, bg 0, no result pending.
// Screen cells are undefined after reset until cleared or written.
module text_console_cell_writer_top (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  tccw_pkg::t_in_item               i_in_data,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output tccw_pkg::t_out_item              o_out_data,
    input  logic                             i_cfg_we,
    input  tccw_pkg::t_cfg_idx               i_cfg_addr,
    input  logic [tccw_pkg::COLOR_W-1:0]     i_cfg_wdata
);

    localparam logic [tccw_pkg::ROW_W-1:0] ROW_LAST = tccw_pkg::ROW_W'(tccw_pkg::ROWS - 1);
    localparam logic [tccw_pkg::COL_W-1:0] COL_LAST = tccw_pkg::COL_W'(tccw_pkg::COLUMNS - 1);

    function automatic logic [tccw_pkg::ADDR_W-1:0] cell_addr(
        input logic [tccw_pkg::ROW_W-1:0] row,
        input logic [tccw_pkg::COL_W-1:0] col
    );
        return tccw_pkg::ADDR_W'(row) * tccw_pkg::ADDR_W'(tccw_pkg::COLUMNS)
             + tccw_pkg::ADDR_W'(col);
    endfunction

    function automatic logic [7:0] clamp8(input logic signed [7:0] v, input int limit);
        logic [7:0] res;
        if (v[7]) begin
            res = '0;
        end else if ({1'b0, v} >= 9'(limit)) begin
            res = 8'(limit - 1);
        end else begin
            res = v;
        end
        return res;
    endfunction

    tccw_pkg::t_state               r_state, n_state;
    tccw_pkg::t_in_item             r_req, n_req;
    logic [tccw_pkg::ROW_W-1:0]     r_row, n_row;
    logic [tccw_pkg::COL_W-1:0]     r_col, n_col;
    logic [tccw_pkg::CELL_W-1:0]    r_cell, n_cell;
    logic                           r_scr, n_scr;
    logic                           r_out_valid, n_out_valid;
    tccw_pkg::t_out_item            r_out_data, n_out_data;
    logic [tccw_pkg::COLOR_W-1:0]   r_fg, r_bg;

    tccw_pkg::t_scr_req             scr_req;
    tccw_pkg::t_scr_sts             scr_sts;
    logic [7:0]                     attr;
    logic [tccw_pkg::CELL_W-1:0]    blank;
    logic                           fin;
    logic                           wrap;

    assign attr  = {r_bg, r_fg};
    assign blank = {attr, tccw_pkg::SPACE_CODE};

    always_comb begin
        n_state     = r_state;
        n_req       = r_req;
        n_row       = r_row;
        n_col       = r_col;
        n_cell      = r_cell;
        n_scr       = r_scr;
        n_out_valid = r_out_valid && i_out_stall;
        n_out_data  = r_out_data;
        scr_req     = '{op: tccw_pkg::SOP_NOP, addr: '0, data: '0};
        fin         = 1'b0;
        wrap        = 1'b0;
        unique case (r_state)
            tccw_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_req   = i_in_data;
                    n_state = tccw_pkg::ST_EXEC;
                end
            end
            tccw_pkg::ST_EXEC: begin
                n_cell = '0;
                n_scr  = 1'b0;
                unique case (r_req.command)
                    tccw_pkg::CMD_PUT: begin
                        if (r_req.char_code != tccw_pkg::NEWLINE_CODE) begin
                            scr_req.op   = tccw_pkg::SOP_WRITE;
                            scr_req.addr = cell_addr(r_row, r_col);
                            scr_req.data = {attr, r_req.char_code};
                        end
                        wrap = (r_req.char_code == tccw_pkg::NEWLINE_CODE) ||
                               (r_col == COL_LAST);
                        if (!wrap) begin
                            n_col = r_col + tccw_pkg::COL_W'(1);
                            fin   = 1'b1;
                        end else if (r_row != ROW_LAST) begin
                            n_col = '0;
                            n_row = r_row + tccw_pkg::ROW_W'(1);
                            fin   = 1'b1;
                        end else begin
                            // past the bottom: cursor stays on the last row
                            n_col = '0;
                            n_scr = 1'b1;
                            if (r_req.char_code == tccw_pkg::NEWLINE_CODE) begin
                                scr_req.op   = tccw_pkg::SOP_SCROLL;
                                scr_req.data = blank;
                                n_state      = tccw_pkg::ST_WAIT;
                            end else begin
                                n_state = tccw_pkg::ST_SCROLL;
                            end
                        end
                    end
                    tccw_pkg::CMD_SET: begin
                        n_row = tccw_pkg::ROW_W'(clamp8(r_req.row, tccw_pkg::ROWS));
                        n_col = tccw_pkg::COL_W'(clamp8(r_req.col, tccw_pkg::COLUMNS));
                        fin   = 1'b1;
                    end
                    tccw_pkg::CMD_CLEAR: begin
                        scr_req.op   = tccw_pkg::SOP_CLEAR;
                        scr_req.data = blank;
                        n_row        = '0;
                        n_col        = '0;
                        n_state      = tccw_pkg::ST_WAIT;
                    end
                    tccw_pkg::CMD_READ: begin
                        scr_req.op   = tccw_pkg::SOP_READ;
                        scr_req.addr = cell_addr(
                            tccw_pkg::ROW_W'(clamp8(r_req.row, tccw_pkg::ROWS)),
                            tccw_pkg::COL_W'(clamp8(r_req.col, tccw_pkg::COLUMNS)));
                        n_state      = tccw_pkg::ST_RDATA;
                    end
                    default: n_state = tccw_pkg::ST_IDLE;
                endcase
            end
            tccw_pkg::ST_SCROLL: begin
                scr_req.op   = tccw_pkg::SOP_SCROLL;
                scr_req.data = blank;
                n_state      = tccw_pkg::ST_WAIT;
            end
            tccw_pkg::ST_WAIT: begin
                fin = !scr_sts.busy;
            end
            tccw_pkg::ST_RDATA: begin
                n_cell = scr_sts.rdata;
                fin    = 1'b1;
            end
            tccw_pkg::ST_DONE: begin
                fin = 1'b1;
            end
            default: n_state = tccw_pkg::ST_IDLE;
        endcase

        if (fin) begin
            if (!r_out_valid || !i_out_stall) begin
                n_out_valid                = 1'b1;
                n_out_data.cursor_row      = 5'(n_row);
                n_out_data.cursor_col      = 7'(n_col);
                n_out_data.cursor_position = 11'(cell_addr(n_row, n_col));
                n_out_data.read_cell       = 16'(n_cell);
                n_out_data.scrolled        = n_scr;
                n_state                    = tccw_pkg::ST_IDLE;
            end else begin
                n_state = tccw_pkg::ST_DONE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= tccw_pkg::ST_IDLE;
            r_row       <= '0;
            r_col       <= '0;
            r_out_valid <= 1'b0;
            r_fg        <= tccw_pkg::FG_RESET;
            r_bg        <= tccw_pkg::BG_RESET;
        end else begin
            r_state     <= n_state;
            r_row       <= n_row;
            r_col       <= n_col;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                unique case (i_cfg_addr)
                    tccw_pkg::CFG_FG: r_fg <= i_cfg_wdata;
                    tccw_pkg::CFG_BG: r_bg <= i_cfg_wdata;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_req      <= n_req;
        r_cell     <= n_cell;
        r_scr      <= n_scr;
        r_out_data <= n_out_data;
    end

    tccw_screen u_screen (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (scr_req),
        .o_sts   (scr_sts)
    );

    assign o_in_stall  = (r_state != tccw_pkg::ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

// ===== rtl/tccw_screen.sv =====
`timescale 1ns / 1ps
// Screen store: cell memory with one write and one registered read port,
// plus the sweep engine for clear and scroll. Depends on tccw_pkg.
module tccw_screen (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  tccw_pkg::t_scr_req i_req,
    output tccw_pkg::t_scr_sts o_sts
);

    logic [tccw_pkg::CELL_W-1:0] mem [tccw_pkg::CELLS];

    tccw_pkg::t_scr_state        r_state, n_state;
    logic [tccw_pkg::ADDR_W-1:0] r_idx, n_idx;
    logic [tccw_pkg::CELL_W-1:0] r_fill, n_fill;
    logic [tccw_pkg::CELL_W-1:0] r_rdata;

    logic                        wr_en;
    logic [tccw_pkg::ADDR_W-1:0] wr_addr;
    logic [tccw_pkg::CELL_W-1:0] wr_data;
    logic                        rd_en;
    logic [tccw_pkg::ADDR_W-1:0] rd_addr;
    logic [tccw_pkg::ADDR_W:0]   ahead;

    localparam logic [tccw_pkg::ADDR_W-1:0] LAST_IDX  = tccw_pkg::ADDR_W'(tccw_pkg::CELLS - 1);
    localparam logic [tccw_pkg::ADDR_W-1:0] COPY_END  =
        tccw_pkg::ADDR_W'(tccw_pkg::CELLS - tccw_pkg::COLUMNS);
    localparam logic [tccw_pkg::ADDR_W-1:0] ROW_SPAN  = tccw_pkg::ADDR_W'(tccw_pkg::COLUMNS);

    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        n_fill  = r_fill;
        wr_en   = 1'b0;
        wr_addr = r_idx;
        wr_data = r_fill;
        rd_en   = 1'b0;
        rd_addr = i_req.addr;
        // source cell for the next shift step, one row below
        ahead   = {1'b0, r_idx} + {1'b0, ROW_SPAN} + (tccw_pkg::ADDR_W+1)'(1);
        unique case (r_state)
            tccw_pkg::SCR_IDLE: begin
                case (i_req.op)
                    tccw_pkg::SOP_WRITE: begin
                        wr_en   = 1'b1;
                        wr_addr = i_req.addr;
                        wr_data = i_req.data;
                    end
                    tccw_pkg::SOP_READ: begin
                        rd_en = 1'b1;
                    end
                    tccw_pkg::SOP_CLEAR: begin
                        n_fill  = i_req.data;
                        n_idx   = '0;
                        n_state = tccw_pkg::SCR_CLEAR;
                    end
                    tccw_pkg::SOP_SCROLL: begin
                        n_fill  = i_req.data;
                        n_idx   = '0;
                        rd_en   = 1'b1;
                        rd_addr = ROW_SPAN;
                        n_state = tccw_pkg::SCR_SHIFT;
                    end
                    default: ;
                endcase
            end
            tccw_pkg::SCR_CLEAR: begin
                wr_en = 1'b1;
                if (r_idx == LAST_IDX) begin
                    n_state = tccw_pkg::SCR_IDLE;
                end else begin
                    n_idx = r_idx + tccw_pkg::ADDR_W'(1);
                end
            end
            tccw_pkg::SCR_SHIFT: begin
                wr_en   = 1'b1;
                wr_data = (r_idx < COPY_END) ? r_rdata : r_fill;
                if (ahead < (tccw_pkg::ADDR_W+1)'(tccw_pkg::CELLS)) begin
                    rd_en   = 1'b1;
                    rd_addr = ahead[tccw_pkg::ADDR_W-1:0];
                end
                if (r_idx == LAST_IDX) begin
                    n_state = tccw_pkg::SCR_IDLE;
                end else begin
                    n_idx = r_idx + tccw_pkg::ADDR_W'(1);
                end
            end
            default: n_state = tccw_pkg::SCR_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tccw_pkg::SCR_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx  <= n_idx;
        r_fill <= n_fill;
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rdata <= mem[rd_addr];
        end
    end

    assign o_sts.busy  = (r_state != tccw_pkg::SCR_IDLE);
    assign o_sts.rdata = r_rdata;

endmodule

// ===== rtl/tccw_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks for the text console cell writer, bound to the top level.
// Depends on tccw_pkg.
module tccw_checker (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    input  logic                             o_in_stall,
    input  tccw_pkg::t_in_item               i_in_data,
    input  logic                             o_out_valid,
    input  logic                             i_out_stall,
    input  tccw_pkg::t_out_item              o_out_data,
    input  logic                             i_cfg_we,
    input  tccw_pkg::t_cfg_idx               i_cfg_addr,
    input  logic [tccw_pkg::COLOR_W-1:0]     i_cfg_wdata
);

    logic in_acc;
    assign in_acc = i_in_valid && !o_in_stall;

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("result dropped or changed under stall");

    // cursor in range and linear position consistent
    a_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (11'(o_out_data.cursor_row) < 11'(tccw_pkg::ROWS)) &&
                        (11'(o_out_data.cursor_col) < 11'(tccw_pkg::COLUMNS)) &&
                        (o_out_data.cursor_position ==
                         11'(o_out_data.cursor_row) * 11'(tccw_pkg::COLUMNS) +
                         11'(o_out_data.cursor_col)))
        else $error("cursor out of range or position mismatch");

    // a scroll always leaves the cursor at the start of the last row
    a_scroll_home: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.scrolled |->
            (5'(o_out_data.cursor_row) == 5'(tccw_pkg::ROWS - 1)) &&
            (o_out_data.cursor_col == '0) && (o_out_data.read_cell == '0))
        else $error("scroll result with cursor off last-row home");

    // one request at a time: input stalls right after a request is taken
    a_one_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> o_in_stall)
        else $error("second request taken while one is in flight");

    logic unused_cfg;
    assign unused_cfg = i_cfg_we ^ i_cfg_addr[0] ^ (|i_cfg_wdata) ^ (|i_in_data);

endmodule

bind text_console_cell_writer_top tccw_checker u_tccw_checker (.*);
